// File: rtl/core/pvs_pkg.sv
// pvs_pkg: shared types, codes and sizes for the property value store
// depends on nothing; imported by pvs_cell, pvs_chain, property_value_store and tb
package pvs_pkg;

  localparam int DEPTH    = 16;
  localparam int MAX_LIST = 16;
  localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int NW       = CNT_W + 5;

  typedef enum logic [2:0] {
    ACT_ATTACH  = 3'd0,
    ACT_RAW_SET = 3'd1,
    ACT_CHK_SET = 3'd2,
    ACT_GET     = 3'd3,
    ACT_LIST    = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_INVALID   = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_NO_SPACE  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_PASS = 2'd1,
    S_DONE = 2'd2
  } state_t;

  // control from the sequencer to the row of cells
  typedef struct packed {
    logic             shift;
    logic             load;
    logic [IDX_W-1:0] idx;
  } chain_ctl_t;

  // low five bits of an entry count
  function automatic logic [4:0] to_cnt5(input logic [CNT_W-1:0] c);
    logic [CNT_W+4:0] w;
    w = {5'b0, c};
    return w[4:0];
  endfunction

endpackage

// File: rtl/core/property_value_store.sv
// property_value_store: top level, request sequencer and output register
// depends on pvs_pkg and pvs_chain
//
//  channel   ports                                   direction
//  in_       valid, stall, action .. range_high      request in
//  out_      valid, stall, status .. last            result out
//
// every request rotates the whole ring once: DEPTH shift steps, then the
// finishing state S_DONE
// a list emits one entry per shift step; a stalled output freezes the ring
// reset clears the sequencer, the entry count and the output valid; the
// entry cells are not cleared, only entries below the count are ever read
// in_stall is high while a request is in progress
module property_value_store
  import pvs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_action,
  input  logic [31:0] in_prop_id,
  input  logic [63:0] in_value,
  input  logic [4:0]  in_list_limit,
  input  logic        in_atomic_flag,
  input  logic        in_immutable_flag,
  input  logic        in_range_flag,
  input  logic [63:0] in_range_low,
  input  logic [63:0] in_range_high,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [63:0] out_read_value,
  output logic [31:0] out_entry_key,
  output logic [63:0] out_entry_value,
  output logic        out_entry_valid,
  output logic [4:0]  out_total_count,
  output logic        out_last
);

  // sequencer state
  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] step_r, step_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             found_r, found_nxt;
  logic [63:0]      rd_r, rd_nxt;

  // captured request
  logic [2:0]       act_r, act_nxt;
  logic [31:0]      key_r, key_nxt;
  logic [63:0]      val_r, val_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic             atomic_r, atomic_nxt;
  logic             immut_r, immut_nxt;
  logic             rbad_r, rbad_nxt;

  // output register
  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       out_status_r, out_status_nxt;
  logic [63:0]      out_rd_r, out_rd_nxt;
  logic [31:0]      out_ekey_r, out_ekey_nxt;
  logic [63:0]      out_eval_r, out_eval_nxt;
  logic             out_evld_r, out_evld_nxt;
  logic [4:0]       out_cnt_r, out_cnt_nxt;
  logic             out_last_r, out_last_nxt;

  chain_ctl_t       ctl;
  logic [63:0]      feed_val;
  logic [31:0]      head_key;
  logic [63:0]      head_val;

  logic             out_free;
  logic             in_table;
  logic             hit;
  logic             ovr_en;
  logic             emit_list;
  logic             advance;
  logic [NW-1:0]    n_wide;
  logic [NW-1:0]    lim_w, cnt_w;

  pvs_chain u_chain (
    .clk      (clk),
    .ctl      (ctl),
    .feed_val (feed_val),
    .ld_key   (key_r),
    .ld_val   (val_r),
    .head_key (head_key),
    .head_val (head_val)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE);

  // entry at the head during step k is table entry k
  assign in_table  = (CNT_W'(step_r) < count_r);
  assign hit       = in_table && (head_key == key_r);
  assign emit_list = (act_r == ACT_LIST) && (CNT_W'(step_r) < n_r);
  assign advance   = !emit_list || out_free;

  // overwrite of a matching entry is decided before the pass
  always_comb begin
    case (act_r)
      ACT_ATTACH:  ovr_en = 1'b1;
      ACT_RAW_SET: ovr_en = (count_r != '0);
      ACT_CHK_SET: ovr_en = !atomic_r && (count_r != '0) && !immut_r && !rbad_r;
      default:     ovr_en = 1'b0;
    endcase
  end

  // list length: smallest of limit, count and the list cap
  always_comb begin
    lim_w  = NW'(in_list_limit);
    cnt_w  = NW'(count_r);
    n_wide = (lim_w < cnt_w) ? lim_w : cnt_w;
    if (n_wide > NW'(MAX_LIST)) begin
      n_wide = NW'(MAX_LIST);
    end
  end

  always_comb begin
    state_nxt      = state_r;
    step_nxt       = step_r;
    count_nxt      = count_r;
    found_nxt      = found_r;
    rd_nxt         = rd_r;
    act_nxt        = act_r;
    key_nxt        = key_r;
    val_nxt        = val_r;
    n_nxt          = n_r;
    atomic_nxt     = atomic_r;
    immut_nxt      = immut_r;
    rbad_nxt       = rbad_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_rd_nxt     = out_rd_r;
    out_ekey_nxt   = out_ekey_r;
    out_eval_nxt   = out_eval_r;
    out_evld_nxt   = out_evld_r;
    out_cnt_nxt    = out_cnt_r;
    out_last_nxt   = out_last_r;
    ctl            = '0;
    feed_val       = head_val;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          act_nxt    = in_action;
          key_nxt    = in_prop_id;
          val_nxt    = in_value;
          n_nxt      = n_wide[CNT_W-1:0];
          atomic_nxt = in_atomic_flag;
          immut_nxt  = in_immutable_flag;
          rbad_nxt   = in_range_flag &&
                       ((in_value < in_range_low) || (in_value > in_range_high));
          step_nxt   = '0;
          found_nxt  = 1'b0;
          rd_nxt     = '0;
          state_nxt  = S_PASS;
        end
      end

      S_PASS: begin
        if (advance) begin
          ctl.shift = 1'b1;
          if (hit) begin
            found_nxt = 1'b1;
            rd_nxt    = head_val;
            if (ovr_en) begin
              feed_val = val_r;
            end
          end
          if (emit_list) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_OK;
            out_rd_nxt     = '0;
            out_ekey_nxt   = head_key;
            out_eval_nxt   = head_val;
            out_evld_nxt   = 1'b1;
            out_cnt_nxt    = to_cnt5(count_r);
            out_last_nxt   = (CNT_W'(step_r) + CNT_W'(1) == n_r);
          end
          step_nxt = step_r + IDX_W'(1);
          if (step_r == IDX_W'(DEPTH - 1)) begin
            step_nxt  = '0;
            state_nxt = S_DONE;
          end
        end
      end

      S_DONE: begin
        if ((act_r == ACT_LIST) && (n_r != '0)) begin
          // entries already went out during the pass
          state_nxt = S_IDLE;
        end else if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_INVALID;
          out_rd_nxt     = '0;
          out_ekey_nxt   = '0;
          out_eval_nxt   = '0;
          out_evld_nxt   = 1'b0;
          out_last_nxt   = 1'b1;
          case (act_r)
            ACT_ATTACH, ACT_RAW_SET: begin
              if ((act_r == ACT_RAW_SET) && (count_r == '0)) begin
                out_status_nxt = ST_INVALID;
              end else if (found_r) begin
                out_status_nxt = ST_OK;
              end else if (count_r < CNT_W'(DEPTH)) begin
                // append at the end of the table
                ctl.load       = 1'b1;
                ctl.idx        = count_r[IDX_W-1:0];
                count_nxt      = count_r + CNT_W'(1);
                out_status_nxt = ST_OK;
              end else begin
                out_status_nxt = ST_NO_SPACE;
              end
            end
            ACT_CHK_SET: begin
              if (atomic_r || (count_r == '0)) begin
                out_status_nxt = ST_INVALID;
              end else if (!found_r) begin
                out_status_nxt = ST_NOT_FOUND;
              end else if (immut_r || rbad_r) begin
                out_status_nxt = ST_INVALID;
              end else begin
                out_status_nxt = ST_OK;
              end
            end
            ACT_GET: begin
              if (found_r) begin
                out_status_nxt = ST_OK;
                out_rd_nxt     = rd_r;
              end
            end
            ACT_LIST: begin
              out_status_nxt = ST_OK;
            end
            default: begin
              out_status_nxt = ST_INVALID;
            end
          endcase
          out_cnt_nxt = to_cnt5(count_nxt);
          state_nxt   = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    found_r      <= found_nxt;
    rd_r         <= rd_nxt;
    act_r        <= act_nxt;
    key_r        <= key_nxt;
    val_r        <= val_nxt;
    n_r          <= n_nxt;
    atomic_r     <= atomic_nxt;
    immut_r      <= immut_nxt;
    rbad_r       <= rbad_nxt;
    out_status_r <= out_status_nxt;
    out_rd_r     <= out_rd_nxt;
    out_ekey_r   <= out_ekey_nxt;
    out_eval_r   <= out_eval_nxt;
    out_evld_r   <= out_evld_nxt;
    out_cnt_r    <= out_cnt_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_read_value  = out_rd_r;
  assign out_entry_key   = out_ekey_r;
  assign out_entry_value = out_eval_r;
  assign out_entry_valid = out_evld_r;
  assign out_total_count = out_cnt_r;
  assign out_last        = out_last_r;

`ifndef SYNTHESIS
  // ring must sit at its home position between requests
  a_idle_home: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_PASS |-> step_r == '0)
    else $error("ring not at home position outside a pass");

  // the table only grows, one entry at a time
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && (count_r != $past(count_r)) |-> count_r == $past(count_r) + CNT_W'(1))
    else $error("entry count moved by other than one");

  // no append into a full table
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load |-> count_r < CNT_W'(DEPTH))
    else $error("append with the table full");

  // a full rotation ends in the finishing state
  a_pass_end: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PASS && advance && step_r == IDX_W'(DEPTH - 1) |=> state_r == S_DONE)
    else $error("pass did not end after a full rotation");
`endif

endmodule

// File: rtl/core/pvs_cell.sv
// pvs_cell: one table entry, a key and a value
// depends on pvs_pkg (imported, no items used)
module pvs_cell
  import pvs_pkg::*;
(
  input  logic        clk,
  input  logic        shift,
  input  logic [31:0] sh_key,
  input  logic [63:0] sh_val,
  input  logic        load,
  input  logic [31:0] ld_key,
  input  logic [63:0] ld_val,
  output logic [31:0] key,
  output logic [63:0] val
);

  logic [31:0] key_r;
  logic [63:0] val_r;
  logic [31:0] key_nxt;
  logic [63:0] val_nxt;

  always_comb begin
    key_nxt = key_r;
    val_nxt = val_r;
    if (shift) begin
      key_nxt = sh_key;
      val_nxt = sh_val;
    end else if (load) begin
      key_nxt = ld_key;
      val_nxt = ld_val;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    val_r <= val_nxt;
  end

  assign key = key_r;
  assign val = val_r;

endmodule

// File: rtl/core/pvs_chain.sv
// pvs_chain: ring of DEPTH entry cells, cell 0 is the head
// depends on pvs_pkg and pvs_cell
module pvs_chain
  import pvs_pkg::*;
(
  input  logic        clk,
  input  chain_ctl_t  ctl,
  input  logic [63:0] feed_val,
  input  logic [31:0] ld_key,
  input  logic [63:0] ld_val,
  output logic [31:0] head_key,
  output logic [63:0] head_val
);

  logic [31:0] key_q [DEPTH];
  logic [63:0] val_q [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [31:0] nb_key;
    logic [63:0] nb_val;
    logic        ld_hit;

    // head entry wraps round to the tail, value possibly replaced
    if (i == DEPTH - 1) begin : g_tail
      assign nb_key = key_q[0];
      assign nb_val = feed_val;
    end else begin : g_mid
      assign nb_key = key_q[i+1];
      assign nb_val = val_q[i+1];
    end

    assign ld_hit = ctl.load && (ctl.idx == IDX_W'(i));

    pvs_cell u_cell (
      .clk    (clk),
      .shift  (ctl.shift),
      .sh_key (nb_key),
      .sh_val (nb_val),
      .load   (ld_hit),
      .ld_key (ld_key),
      .ld_val (ld_val),
      .key    (key_q[i]),
      .val    (val_q[i])
    );
  end

  assign head_key = key_q[0];
  assign head_val = val_q[0];

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps
// tb: self-checking bench for property_value_store, directed table then random requests
// depends on pvs_pkg and the property_value_store rtl; needs no files or arguments
module tb;
  import pvs_pkg::*;

  localparam int          QUIET_LIMIT    = 3000;  // cycles with no handshake on either side
  localparam int          RAND_PER_PHASE = 100;
  localparam int          MAX_REPORTS    = 50;
  localparam logic [2:0]  ACT_UNKNOWN_LO = 3'd5;  // undefined action codes
  localparam logic [2:0]  ACT_UNKNOWN_HI = 3'd7;
  localparam logic [2:0]  F_NONE         = 3'b000;  // {atomic, immutable, range}
  localparam logic [2:0]  F_ATOMIC       = 3'b100;
  localparam logic [2:0]  F_IMMUT        = 3'b010;
  localparam logic [2:0]  F_RANGE        = 3'b001;
  localparam logic [63:0] ONES64         = {64{1'b1}};
  localparam logic [31:0] ONES32         = {32{1'b1}};

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] prop_id;
    logic [63:0] value;
    logic [4:0]  list_limit;
    logic        atomic;
    logic        immut;
    logic        ranged;
    logic [63:0] lo;
    logic [63:0] hi;
  } request_t;

  typedef struct packed {
    status_t     status;
    logic [63:0] read_value;
    logic [31:0] entry_key;
    logic [63:0] entry_value;
    logic        entry_valid;
    logic [4:0]  total_count;
    logic        last;
  } reply_t;

  // one line of the directed table; reps > 1 repeats it with the id counting up
  typedef struct {
    request_t req;
    int       reps;
    bit       typed;
    status_t  t_status;
    int       t_count;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  request_t    drv = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [63:0] out_read_value;
  logic [31:0] out_entry_key;
  logic [63:0] out_entry_value;
  logic        out_entry_valid;
  logic [4:0]  out_total_count;
  logic        out_last;

  // mirror of the table contents, updated on every accepted request
  logic [31:0] mirror_keys [DEPTH];
  logic [63:0] mirror_vals [DEPTH];
  int          mirror_count = 0;

  reply_t      pending_replies[$];  // replies still owed by the block, oldest first
  reply_t      fresh_replies[$];    // replies worked out for the request just taken

  // hand-typed expectation for the request now on the port
  bit          typed_pending = 1'b0;
  status_t     typed_status = ST_OK;
  int          typed_count = 0;

  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          mismatch_count = 0;
  int          sent_count = 0;
  int          reply_count = 0;
  int          list_entries = 0;
  int          status_seen [4] = '{0, 0, 0, 0};
  int          quiet_cycles = 0;

  property_value_store u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_action         (drv.action),
    .in_prop_id        (drv.prop_id),
    .in_value          (drv.value),
    .in_list_limit     (drv.list_limit),
    .in_atomic_flag    (drv.atomic),
    .in_immutable_flag (drv.immut),
    .in_range_flag     (drv.ranged),
    .in_range_low      (drv.lo),
    .in_range_high     (drv.hi),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_read_value    (out_read_value),
    .out_entry_key     (out_entry_key),
    .out_entry_value   (out_entry_value),
    .out_entry_valid   (out_entry_valid),
    .out_total_count   (out_total_count),
    .out_last          (out_last)
  );

  // 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic log_mismatch(input string what);
    if (mismatch_count < MAX_REPORTS) begin
      $display("mismatch at %0t: %s", $realtime, what);
    end
    mismatch_count++;
  endtask

  task automatic cmp_field(input string name, input logic [63:0] got, input logic [63:0] want);
    if (got !== want) begin
      log_mismatch($sformatf("reply %0d %s is %h, expected %h", reply_count, name, got, want));
    end
  endtask

  // ---------------------------------------------------------------------------
  // table mirror: linear search from the first entry, append at the end
  // ---------------------------------------------------------------------------
  function automatic int find_key(input logic [31:0] k);
    for (int i = 0; i < mirror_count; i++) begin
      if (mirror_keys[i] == k) return i;
    end
    return -1;
  endfunction

  // overwrite a match, else append; a full table refuses the append
  function automatic status_t store_pair(input logic [31:0] k, input logic [63:0] v);
    int slot;
    slot = find_key(k);
    if (slot >= 0) begin
      mirror_vals[slot] = v;
      return ST_OK;
    end
    if (mirror_count >= DEPTH) return ST_NO_SPACE;
    mirror_keys[mirror_count] = k;
    mirror_vals[mirror_count] = v;
    mirror_count++;
    return ST_OK;
  endfunction

  function automatic reply_t make_reply(input status_t st, input logic [63:0] rd,
                                        input logic [31:0] ek, input logic [63:0] ev,
                                        input logic evalid, input logic lst);
    reply_t r;
    r.status      = st;
    r.read_value  = rd;
    r.entry_key   = ek;
    r.entry_value = ev;
    r.entry_valid = evalid;
    r.total_count = 5'(mirror_count);
    r.last        = lst;
    return r;
  endfunction

  // applies one request to the mirror and leaves its replies in fresh_replies
  function automatic void predict_replies(input request_t r);
    int          slot;
    int          n;
    status_t     st;
    logic [63:0] rd;
    rd = '0;
    st = ST_INVALID;
    fresh_replies.delete();
    case (r.action)
      ACT_ATTACH: begin
        st = store_pair(r.prop_id, r.value);
      end
      ACT_RAW_SET: begin
        // raw set needs at least one entry already present
        if (mirror_count != 0) st = store_pair(r.prop_id, r.value);
      end
      ACT_CHK_SET: begin
        // access rules in priority order: atomic or empty, absent, immutable, bounds
        slot = find_key(r.prop_id);
        if (r.atomic || mirror_count == 0) st = ST_INVALID;
        else if (slot < 0) st = ST_NOT_FOUND;
        else if (r.immut) st = ST_INVALID;
        else if (r.ranged && (r.value < r.lo || r.value > r.hi)) st = ST_INVALID;
        else begin
          mirror_vals[slot] = r.value;
          st = ST_OK;
        end
      end
      ACT_GET: begin
        slot = find_key(r.prop_id);
        if (slot >= 0) begin
          rd = mirror_vals[slot];
          st = ST_OK;
        end
      end
      ACT_LIST: begin
        n = r.list_limit;
        if (n > mirror_count) n = mirror_count;
        if (n > MAX_LIST) n = MAX_LIST;
        if (n > 0) begin
          for (int i = 0; i < n; i++) begin
            fresh_replies.push_back(make_reply(ST_OK, '0, mirror_keys[i], mirror_vals[i],
                                               1'b1, i == n - 1));
          end
          return;
        end
        // nothing to list: one bare reply
        st = ST_OK;
      end
      default: st = ST_INVALID;
    endcase
    fresh_replies.push_back(make_reply(st, rd, '0, '0, 1'b0, 1'b1));
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic stim_row_t mk_row(input logic [2:0] act, input logic [31:0] id,
                                       input logic [63:0] v, input int lim,
                                       input logic [2:0] fl, input logic [63:0] lo,
                                       input logic [63:0] hi, input int reps,
                                       input bit typed, input status_t st, input int cnt);
    stim_row_t row;
    row.req.action     = act;
    row.req.prop_id    = id;
    row.req.value      = v;
    row.req.list_limit = 5'(lim);
    {row.req.atomic, row.req.immut, row.req.ranged} = fl;
    row.req.lo         = lo;
    row.req.hi         = hi;
    row.reps           = reps;
    row.typed          = typed;
    row.t_status       = st;
    row.t_count        = cnt;
    return row;
  endfunction

  function automatic request_t random_request();
    request_t    r;
    int          pick;
    logic [63:0] a;
    logic [63:0] b;
    r = '0;
    pick = $urandom_range(99);
    if (pick < 20) r.action = ACT_ATTACH;
    else if (pick < 35) r.action = ACT_RAW_SET;
    else if (pick < 65) r.action = ACT_CHK_SET;
    else if (pick < 83) r.action = ACT_GET;
    else if (pick < 95) r.action = ACT_LIST;
    else r.action = 3'($urandom_range(ACT_UNKNOWN_HI, ACT_UNKNOWN_LO));
    // mostly ids already stored so that updates and reads hit a slot
    if (mirror_count > 0 && $urandom_range(99) < 70) begin
      r.prop_id = mirror_keys[$urandom_range(mirror_count - 1)];
    end else begin
      r.prop_id = $urandom();
    end
    r.value      = {$urandom(), $urandom()};
    r.list_limit = 5'($urandom_range(MAX_LIST));
    r.atomic     = ($urandom_range(99) < 10);
    r.immut      = ($urandom_range(99) < 15);
    r.ranged     = ($urandom_range(99) < 50);
    a = {$urandom(), $urandom()};
    b = {$urandom(), $urandom()};
    if ($urandom_range(1) == 1) begin
      // ordered bounds with the value on an edge or inside
      r.lo = (a < b) ? a : b;
      r.hi = (a < b) ? b : a;
      case ($urandom_range(2))
        0:       r.value = r.lo;
        1:       r.value = r.hi;
        default: r.value = r.lo + (r.hi - r.lo) / 2;
      endcase
    end else begin
      r.lo = a;
      r.hi = b;
    end
    return r;
  endfunction

  // present one request at the falling edge, hold it until taken at a rising edge
  task automatic send_request(input request_t r, input bit typed, input status_t t_st,
                              input int t_cnt);
    forever begin
      @(negedge clk);
      if (send_idle_pct == 0 || $urandom_range(99) >= send_idle_pct) break;
      in_valid <= 1'b0;
    end
    typed_pending = typed;
    typed_status  = t_st;
    typed_count   = t_cnt;
    drv      <= r;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sent_count++;
  endtask

  // ---------------------------------------------------------------------------
  // receiver back-pressure, changed at the falling edge only
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // monitor: requests taken feed the mirror, replies taken are checked in order
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    reply_t got;
    reply_t typed_reply;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_replies(drv);
        if (typed_pending) begin
          // the hand-typed reply stands in for the mirror's
          typed_reply = make_reply(typed_status, '0, '0, '0, 1'b0, 1'b1);
          typed_reply.total_count = 5'(typed_count);
          pending_replies.push_back(typed_reply);
        end else begin
          foreach (fresh_replies[i]) pending_replies.push_back(fresh_replies[i]);
        end
      end
      if (out_valid && !out_stall) begin
        got.status      = status_t'(out_status);
        got.read_value  = out_read_value;
        got.entry_key   = out_entry_key;
        got.entry_value = out_entry_value;
        got.entry_valid = out_entry_valid;
        got.total_count = out_total_count;
        got.last        = out_last;
        status_seen[out_status]++;
        if (out_entry_valid) list_entries++;
        if (pending_replies.size() == 0) begin
          log_mismatch($sformatf("reply %0d arrived with nothing expected", reply_count));
        end else begin
          typed_reply = pending_replies.pop_front();
          cmp_field("status", 64'(got.status), 64'(typed_reply.status));
          cmp_field("read_value", got.read_value, typed_reply.read_value);
          cmp_field("entry_key", 64'(got.entry_key), 64'(typed_reply.entry_key));
          cmp_field("entry_value", got.entry_value, typed_reply.entry_value);
          cmp_field("entry_valid", 64'(got.entry_valid), 64'(typed_reply.entry_valid));
          cmp_field("total_count", 64'(got.total_count), 64'(typed_reply.total_count));
          cmp_field("last", 64'(got.last), 64'(typed_reply.last));
        end
        reply_count++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: a long stretch with no handshake at all means the block hung
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
      $display("property_value_store regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    stim_row_t dir_rows[$];
    request_t  r;
    int        send_pcts [4];
    int        recv_pcts [4];
    send_pcts = '{0, 70, 0, 22};
    recv_pcts = '{0, 0, 70, 22};

    // empty table: reads, sets and a list all see no entries
    dir_rows.push_back(mk_row(ACT_GET, 32'h0, '0, 0, F_NONE, '0, '0, 1, 1, ST_INVALID, 0));
    dir_rows.push_back(mk_row(ACT_LIST, 32'h0, '0, 16, F_NONE, '0, '0, 1, 1, ST_OK, 0));
    dir_rows.push_back(mk_row(ACT_RAW_SET, 32'h1, ONES64, 0, F_NONE, '0, '0, 1, 1,
                              ST_INVALID, 0));
    dir_rows.push_back(mk_row(ACT_CHK_SET, 32'h1, ONES64, 0, F_NONE, '0, '0, 1, 1,
                              ST_INVALID, 0));
    // extreme ids and values, then a list of what is there
    dir_rows.push_back(mk_row(ACT_ATTACH, 32'h0, '0, 0, F_NONE, '0, '0, 1, 1, ST_OK, 1));
    dir_rows.push_back(mk_row(ACT_ATTACH, ONES32, ONES64, 0, F_NONE, '0, '0, 1, 1, ST_OK, 2));
    dir_rows.push_back(mk_row(ACT_LIST, 32'h0, '0, 16, F_NONE, '0, '0, 1, 0, ST_OK, 0));
    // fill the remaining fourteen slots
    dir_rows.push_back(mk_row(ACT_ATTACH, 32'h100, 64'h5555_aaaa_5555_aaaa, 0, F_NONE,
                              '0, '0, DEPTH - 2, 0, ST_OK, 0));
    // full table: new ids are refused, a known id still updates
    dir_rows.push_back(mk_row(ACT_ATTACH, 32'hcafe_0000, '0, 0, F_NONE, '0, '0, 1, 1,
                              ST_NO_SPACE, DEPTH));
    dir_rows.push_back(mk_row(ACT_RAW_SET, 32'hcafe_0001, '0, 0, F_NONE, '0, '0, 1, 1,
                              ST_NO_SPACE, DEPTH));
    dir_rows.push_back(mk_row(ACT_RAW_SET, 32'h0, 64'haaaa_5555_aaaa_5555, 0, F_NONE,
                              '0, '0, 1, 0, ST_OK, 0));
    // checked set: each rule on its own
    dir_rows.push_back(mk_row(ACT_CHK_SET, ONES32, '0, 0, F_ATOMIC, '0, '0, 1, 1,
                              ST_INVALID, DEPTH));
    dir_rows.push_back(mk_row(ACT_CHK_SET, 32'hdead_0000, '0, 0, F_NONE, '0, '0, 1, 1,
                              ST_NOT_FOUND, DEPTH));
    dir_rows.push_back(mk_row(ACT_CHK_SET, 32'h0, '0, 0, F_IMMUT, '0, '0, 1, 1,
                              ST_INVALID, DEPTH));
    dir_rows.push_back(mk_row(ACT_CHK_SET, 32'h0, 64'd99, 0, F_RANGE, 64'd100, 64'd200, 1, 1,
                              ST_INVALID, DEPTH));
    dir_rows.push_back(mk_row(ACT_CHK_SET, 32'h0, 64'd201, 0, F_RANGE, 64'd100, 64'd200, 1, 1,
                              ST_INVALID, DEPTH));
    dir_rows.push_back(mk_row(ACT_CHK_SET, 32'h0, 64'd200, 0, F_RANGE, 64'd100, 64'd200, 1, 0,
                              ST_OK, 0));
    dir_rows.push_back(mk_row(ACT_CHK_SET, ONES32, ONES64, 0, F_RANGE, '0, ONES64, 1, 0,
                              ST_OK, 0));
    dir_rows.push_back(mk_row(ACT_GET, ONES32, '0, 0, F_NONE, '0, '0, 1, 0, ST_OK, 0));
    // undefined action codes change nothing
    dir_rows.push_back(mk_row(ACT_UNKNOWN_LO, 32'h0, ONES64, 16, F_NONE, '0, '0, 1, 1,
                              ST_INVALID, DEPTH));
    dir_rows.push_back(mk_row(ACT_UNKNOWN_HI, ONES32, ONES64, 16, F_NONE, '0, '0, 1, 1,
                              ST_INVALID, DEPTH));
    // list with a zero limit, a short one and the whole table
    dir_rows.push_back(mk_row(ACT_LIST, 32'h0, '0, 0, F_NONE, '0, '0, 1, 1, ST_OK, DEPTH));
    dir_rows.push_back(mk_row(ACT_LIST, 32'h0, '0, 1, F_NONE, '0, '0, 1, 0, ST_OK, 0));
    dir_rows.push_back(mk_row(ACT_LIST, 32'h0, '0, 16, F_NONE, '0, '0, 1, 0, ST_OK, 0));

    // synchronous reset, released at a falling edge
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table, no idling
    foreach (dir_rows[i]) begin
      for (int k = 0; k < dir_rows[i].reps; k++) begin
        r = dir_rows[i].req;
        r.prop_id = r.prop_id + 32'(k);
        send_request(r, dir_rows[i].typed, dir_rows[i].t_status, dir_rows[i].t_count);
      end
    end

    // random requests under four idle mixes: none, sender, receiver, both
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = send_pcts[ph];
      recv_stall_pct = recv_pcts[ph];
      repeat (RAND_PER_PHASE) send_request(random_request(), 1'b0, ST_OK, 0);
    end

    @(negedge clk);
    in_valid <= 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;

    // drain, then allow one more full ring pass for any stray reply
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (DEPTH + 8) @(posedge clk);

    $display("ran %0d requests, checked %0d replies including %0d listed entries",
             sent_count, reply_count, list_entries);
    $display("statuses seen: ok %0d, invalid %0d, not_found %0d, no_space %0d; %0d mismatches",
             status_seen[ST_OK], status_seen[ST_INVALID], status_seen[ST_NOT_FOUND],
             status_seen[ST_NO_SPACE], mismatch_count);
    if (mismatch_count == 0 && pending_replies.size() == 0) begin
      $display("property_value_store regression: pass");
    end else begin
      $display("property_value_store regression: fail");
    end
    $finish;
  end

endmodule
